/* design/cyclic_code_encode_correct_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the cyclic code encoder and corrector
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CYCLIC_CODE_ENCODE_CORRECT_ASSERT_SVH
`define CYCLIC_CODE_ENCODE_CORRECT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cyclic code assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CCE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cyclic code assertion failed");

`endif

/* design/cce_pkg.sv */
// ----------------------------------------------------------------------------
// Cyclic code package
// Widths and codes shared by the encoder and its checker, and the encoder's remainder step.
// ----------------------------------------------------------------------------
`default_nettype none

package cce_pkg;

  localparam int unsigned WordW        = 32;
  localparam int unsigned SynW         = 16;
  localparam int unsigned GenW         = 17;
  localparam int unsigned LenW         = 6;
  localparam int unsigned PosW         = 5;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 17;
  localparam int unsigned ChunkSize    = 8;
  localparam int unsigned NumChunks    = WordW / ChunkSize;
  localparam int unsigned SettleCycles = NumChunks;
  localparam int unsigned SettleW      = $clog2(SettleCycles + 1);
  localparam int unsigned OutDataW     = ((WordW + SynW + PosW + 2 + 7) / 8) * 8;

  localparam logic [GenW-1:0] GenPolyReset = GenW'(11);
  localparam logic [LenW-1:0] CodeLenReset = LenW'(7);

  typedef logic [SynW-1:0] syn_t;
  typedef logic [GenW-1:0] gen_t;
  typedef logic [WordW-1:0] word_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGenPoly = 2'd0,
    CfgCodeLen = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    OpEncode  = 1'b0,
    OpCorrect = 1'b1
  } op_e;

  // Remainder of x times a remainder, reduced by the generator.
  function automatic syn_t next_rem(syn_t rem, gen_t gen, gen_t top);
    gen_t t;
    t = {rem, 1'b0};
    if ((t & top) != '0) begin
      t = t ^ gen;
    end
    return t[SynW-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/cyclic_code_encode_correct.sv */
// ----------------------------------------------------------------------------
// Cyclic code encoder and single-bit corrector
// Systematic encoding and syndrome-based single error correction, pipelined.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel: data_word in tdata, opcode in tuser;
// bits at and above the code length are cleared. Opcode encode returns the
// word XOR its remainder modulo the generator; opcode correct returns the
// syndrome and flips the lowest bit position whose remainder equals it, or
// flags the word as uncorrectable. Results leave on m_axis; the generator and
// code length are written on the cfg channel, which always accepts.
// One item is accepted per cycle while no stall holds the pipeline and the
// table has settled; the edge that accepts an item loads the first of the
// mask, syndrome, match and select stages, and the select stage offers it.
// The table of per-position remainders is rebuilt by a chain of four
// registered groups of eight positions, so input is held off by a settle
// counter after reset and after every configuration write.
// When the receiver stalls, full stages hold through the combinational chain
// of stage enables; bubbles still fill, and nothing is lost or repeated.
// Reset loads generator 11 and length 7 and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module cyclic_code_encode_correct (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cce_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cce_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // data_word[31:0]
  input  logic [cce_pkg::WordW-1:0]     s_axis_tdata,
  // opcode[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // result_word[31:0], syndrome[47:32], error_position[52:48],
  // was_corrected[53], uncorrectable[54], zero fill[55]
  output logic [cce_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned WordW = cce_pkg::WordW;
  localparam int unsigned SynW  = cce_pkg::SynW;
  localparam int unsigned PosW  = cce_pkg::PosW;
  localparam int unsigned LenW  = cce_pkg::LenW;
  localparam int unsigned Half  = WordW / 2;

  cce_pkg::gen_t              gen_q, top_q, top_d;
  logic [LenW-1:0]            len_q;
  cce_pkg::word_t             mask_q, mask_d;
  cce_pkg::syn_t              tab_q [WordW];
  cce_pkg::syn_t              tab_d [WordW];
  cce_pkg::syn_t              seed;
  logic [cce_pkg::SettleW-1:0] settle_q, settle_d;
  logic                       cfg_we;

  logic             en1, en2, en3, en4;
  logic             v1_q, v2_q, v3_q, v4_q;
  cce_pkg::op_e     op1_q, op2_q, op3_q;
  cce_pkg::word_t   w1_q, w2_q, w3_q;
  cce_pkg::syn_t    plo_q, phi_q, plo_d, phi_d;
  cce_pkg::syn_t    syn3_q, syn3_d;
  cce_pkg::word_t   match3_q, match3_d;
  cce_pkg::word_t   res_q, res_d, low_sel;
  cce_pkg::syn_t    syn_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             corr_q, corr_d, unc_q, unc_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q    <= cce_pkg::GenPolyReset;
      len_q    <= cce_pkg::CodeLenReset;
      settle_q <= cce_pkg::SettleW'(cce_pkg::SettleCycles);
    end else begin
      settle_q <= settle_d;
      if (cfg_we) begin
        unique case (cfg_index_i)
          cce_pkg::CfgGenPoly: gen_q <= cfg_data_i[cce_pkg::GenW-1:0];
          cce_pkg::CfgCodeLen: len_q <= cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    settle_d = settle_q;
    if (cfg_we) begin
      settle_d = cce_pkg::SettleW'(cce_pkg::SettleCycles);
    end else if (settle_q != '0) begin
      settle_d = settle_q - 1'b1;
    end
  end

  always_comb begin
    top_d = '0;
    for (int b = 0; b < int'(cce_pkg::GenW); b++) begin
      if (gen_q[b]) begin
        top_d = '0;
        top_d[b] = 1'b1;
      end
    end
    for (int i = 0; i < int'(WordW); i++) begin
      mask_d[i] = (LenW'(i) < len_q);
    end
  end

  // A generator of degree zero, or none at all, leaves every remainder zero.
  assign seed = (top_q[0] || top_q == '0) ? '0 : SynW'(1);

  always_comb begin
    tab_d[0] = seed;
    for (int i = 1; i < int'(WordW); i++) begin
      if ((i & (int'(cce_pkg::ChunkSize) - 1)) == 0) begin
        tab_d[i] = cce_pkg::next_rem(tab_q[i-1], gen_q, top_q);
      end else begin
        tab_d[i] = cce_pkg::next_rem(tab_d[i-1], gen_q, top_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    mask_q <= mask_d;
    tab_q  <= tab_d;
  end

  assign en4 = !v4_q || m_axis_tready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1 && (settle_q == '0);

  always_comb begin
    plo_d = '0;
    phi_d = '0;
    for (int i = 0; i < int'(Half); i++) begin
      if (w1_q[i]) begin
        plo_d = plo_d ^ tab_q[i];
      end
      if (w1_q[i+Half]) begin
        phi_d = phi_d ^ tab_q[i+Half];
      end
    end
  end

  always_comb begin
    syn3_d = plo_q ^ phi_q;
    for (int i = 0; i < int'(WordW); i++) begin
      match3_d[i] = mask_q[i] && (tab_q[i] == syn3_d) && (syn3_d != '0) &&
                    (op2_q == cce_pkg::OpCorrect);
    end
  end

  always_comb begin
    pos_d = '0;
    for (int i = int'(WordW) - 1; i >= 0; i--) begin
      if (match3_q[i]) begin
        pos_d = PosW'(i);
      end
    end
    low_sel = match3_q & (~match3_q + 1'b1);
    corr_d  = (match3_q != '0);
    unc_d   = (op3_q == cce_pkg::OpCorrect) && (syn3_q != '0) && !corr_d;
    if (op3_q == cce_pkg::OpEncode) begin
      res_d = w3_q ^ {{(WordW-SynW){1'b0}}, syn3_q};
    end else begin
      res_d = w3_q ^ low_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid && s_axis_tready;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      op1_q <= cce_pkg::op_e'(s_axis_tuser);
      w1_q  <= s_axis_tdata & mask_q;
    end
    if (en2) begin
      op2_q <= op1_q;
      w2_q  <= w1_q;
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
    if (en3) begin
      op3_q    <= op2_q;
      w3_q     <= w2_q;
      syn3_q   <= syn3_d;
      match3_q <= match3_d;
    end
    if (en4) begin
      res_q  <= res_d;
      syn_q  <= syn3_q;
      pos_q  <= pos_d;
      corr_q <= corr_d;
      unc_q  <= unc_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {{(cce_pkg::OutDataW - WordW - SynW - PosW - 2){1'b0}},
                          unc_q, corr_q, pos_q, syn_q, res_q};

endmodule

`default_nettype wire

/* design/cce_checker.sv */
// ----------------------------------------------------------------------------
// Cyclic code output checker
// Port-level checks on the result channel of the encoder and corrector.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cyclic_code_encode_correct_assert.svh"

module cce_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [cce_pkg::OutDataW-1:0]  m_axis_tdata
);

  logic [cce_pkg::SynW-1:0] syn;
  logic [cce_pkg::PosW-1:0] pos;
  logic                     corr, unc;

  assign syn  = m_axis_tdata[47:32];
  assign pos  = m_axis_tdata[52:48];
  assign corr = m_axis_tdata[53];
  assign unc  = m_axis_tdata[54];

  `CCE_ASSERT_NXT(a_valid_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `CCE_ASSERT_NXT(a_data_holds, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `CCE_ASSERT_IMP(a_flags_exclusive, m_axis_tvalid, !(corr && unc))
  `CCE_ASSERT_IMP(a_pos_zero, m_axis_tvalid && !corr, pos == '0)
  `CCE_ASSERT_IMP(a_flag_needs_syn, m_axis_tvalid && (corr || unc), syn != '0)

endmodule

bind cyclic_code_encode_correct cce_checker u_cce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* tb/sv/tb_cyclic_code_encode_correct.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the cyclic code encoder and single-bit corrector
// Items are predicted from a local copy of the generator and code length,
// queued on acceptance and compared field by field with each result, under
// random idling on both channels and a long stall on the result side.
// ----------------------------------------------------------------------------

module tb_cyclic_code_encode_correct;

  localparam int unsigned WordW    = cce_pkg::WordW;
  localparam int unsigned SynW     = cce_pkg::SynW;
  localparam int unsigned GenW     = cce_pkg::GenW;
  localparam int unsigned LenW     = cce_pkg::LenW;
  localparam int unsigned PosW     = cce_pkg::PosW;
  localparam int unsigned CfgIdxW  = cce_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = cce_pkg::CfgDataW;
  localparam int unsigned OutDataW = cce_pkg::OutDataW;

  localparam int StallLimit      = 2000;
  localparam int DrainCycles     = 8;
  localparam int LongHoldCycles  = 60;
  localparam int MaxReported     = 10;

  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef struct packed {
    cce_pkg::word_t       word;
    cce_pkg::syn_t        syn;
    logic [PosW-1:0]      pos;
    logic                 fixed;
    logic                 unc;
  } codec_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [WordW-1:0]     s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;

  cce_pkg::gen_t        active_gen = cce_pkg::GenPolyReset;
  logic [LenW-1:0]      active_len = cce_pkg::CodeLenReset;
  codec_result_t        pending_results[$];
  codec_result_t        seen_result;
  codec_result_t        due_result;
  int                   error_count = 0;
  int                   idle_cycles = 0;
  bit                   idle_on = 1'b0;
  bit                   hold_request = 1'b0;
  bit                   offering = 1'b0;

  cyclic_code_encode_correct i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic cce_pkg::syn_t gf2_mod(cce_pkg::word_t w, cce_pkg::gen_t g);
    int             deg;
    cce_pkg::word_t acc;
    deg = -1;
    acc = w;
    for (int b = GenW - 1; b >= 0; b--) begin
      if (g[b] && deg < 0) begin
        deg = b;
      end
    end
    if (deg < 0) begin
      return '0;
    end
    for (int b = WordW - 1; b >= deg; b--) begin
      if (acc[b]) begin
        acc = acc ^ (cce_pkg::word_t'(g) << (b - deg));
      end
    end
    return acc[SynW-1:0];
  endfunction

  function automatic int span_bits();
    return (active_len > WordW) ? WordW : int'(active_len);
  endfunction

  function automatic cce_pkg::word_t span_mask();
    logic [WordW:0] m;
    m = ((WordW + 1)'(1) << span_bits()) - 1'b1;
    return m[WordW-1:0];
  endfunction

  function automatic codec_result_t predict_codec(cce_pkg::op_e op, cce_pkg::word_t data);
    codec_result_t  r;
    cce_pkg::word_t w;
    w = data & span_mask();
    r = '0;
    r.syn = gf2_mod(w, active_gen);
    r.word = w;
    if (op == cce_pkg::OpEncode) begin
      r.word = w ^ cce_pkg::word_t'(r.syn);
    end else if (r.syn != '0) begin
      r.unc = 1'b1;
      // Walk downward so that the lowest matching position is kept.
      for (int i = span_bits() - 1; i >= 0; i--) begin
        if (gf2_mod(cce_pkg::word_t'(1) << i, active_gen) == r.syn) begin
          r.word = w ^ (cce_pkg::word_t'(1) << i);
          r.pos = PosW'(i);
          r.fixed = 1'b1;
          r.unc = 1'b0;
        end
      end
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic end_items();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_item(cce_pkg::op_e op, cce_pkg::word_t data);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      end_items();
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= op;
    offering = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    pending_results.push_back(predict_codec(op, data));
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    end_items();
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    unique case (idx)
      cce_pkg::CfgGenPoly: active_gen = data;
      cce_pkg::CfgCodeLen: active_len = data[LenW-1:0];
      default: ;
    endcase
  endtask

  function automatic cce_pkg::word_t make_word(cce_pkg::op_e op);
    cce_pkg::word_t cw;
    int             n;
    n = span_bits();
    if (op == cce_pkg::OpEncode || $urandom_range(0, 9) >= 8) begin
      return $urandom;
    end
    cw = $urandom & span_mask();
    cw = cw ^ cce_pkg::word_t'(gf2_mod(cw, active_gen));
    if (n > 0 && $urandom_range(0, 3) != 0) begin
      cw = cw ^ (cce_pkg::word_t'(1) << $urandom_range(0, n - 1));
    end
    return cw;
  endfunction

  task automatic test_reset_defaults();
    send_item(cce_pkg::OpEncode, 32'h0000_0000);
    send_item(cce_pkg::OpEncode, 32'hFFFF_FFFF);
    send_item(cce_pkg::OpEncode, 32'h0000_0050);
    send_item(cce_pkg::OpCorrect, 32'h0000_0000);
    send_item(cce_pkg::OpCorrect, 32'hFFFF_FFFF);
    send_item(cce_pkg::OpCorrect, 32'h0000_0051);
    end_items();
  endtask

  task automatic test_special_cases();
    // A zero generator leaves every remainder at zero.
    write_register(cce_pkg::CfgGenPoly, 17'h0_0000);
    write_register(cce_pkg::CfgCodeLen, 17'd32);
    send_item(cce_pkg::OpEncode, 32'hDEAD_BEEF);
    send_item(cce_pkg::OpCorrect, 32'hDEAD_BEEF);
    // A generator of degree zero divides everything.
    write_register(cce_pkg::CfgGenPoly, 17'h0_0001);
    send_item(cce_pkg::OpEncode, 32'h8000_0001);
    send_item(cce_pkg::OpCorrect, 32'h1234_5678);
    // With three positions only, syndrome three has no match.
    write_register(cce_pkg::CfgGenPoly, 17'd11);
    write_register(cce_pkg::CfgCodeLen, 17'd3);
    send_item(cce_pkg::OpCorrect, 32'h0000_0003);
    send_item(cce_pkg::OpCorrect, 32'h0000_0004);
    // Beyond the period of the generator two positions share a syndrome.
    write_register(cce_pkg::CfgCodeLen, 17'd32);
    send_item(cce_pkg::OpCorrect, 32'h0000_0080);
    // All generator bits set, and a length field at its top value.
    write_register(cce_pkg::CfgGenPoly, 17'h1_FFFF);
    write_register(cce_pkg::CfgCodeLen, 17'h1_FFFF);
    send_item(cce_pkg::OpEncode, 32'hFFFF_FFFF);
    send_item(cce_pkg::OpCorrect, 32'h8000_0000);
    send_item(cce_pkg::OpCorrect, 32'h1234_5678);
    write_register(cce_pkg::CfgCodeLen, 17'h1_FFC0);
    send_item(cce_pkg::OpEncode, 32'hFFFF_FFFF);
    send_item(cce_pkg::OpCorrect, 32'hFFFF_FFFF);
    // Writes to unused indexes must leave the configuration alone.
    write_register(CfgSpareB, 17'h1_FFFF);
    send_item(cce_pkg::OpCorrect, 32'h0F0F_0F0F);
    end_items();
  endtask

  task automatic random_config();
    int deg;
    if ($urandom_range(0, 3) == 0) begin
      write_register(logic'($urandom_range(0, 1)) ? CfgSpareA : CfgSpareB, CfgDataW'($urandom));
    end
    if ($urandom_range(0, 5) == 0) begin
      write_register(cce_pkg::CfgGenPoly, CfgDataW'($urandom_range(0, 131071)));
    end else begin
      deg = $urandom_range(2, 16);
      write_register(cce_pkg::CfgGenPoly,
                     CfgDataW'((1 << deg) | ($urandom & ((1 << deg) - 1)) | 1));
    end
    if ($urandom_range(0, 7) == 0) begin
      write_register(cce_pkg::CfgCodeLen, CfgDataW'($urandom));
    end else begin
      write_register(cce_pkg::CfgCodeLen,
                     CfgDataW'(($urandom & 32'h1_FFC0) | $urandom_range(3, 32)));
    end
  endtask

  task automatic run_items(int count);
    cce_pkg::op_e op;
    for (int k = 0; k < count; k++) begin
      op = cce_pkg::op_e'($urandom_range(0, 1));
      send_item(op, make_word(op));
    end
    end_items();
  endtask

  task automatic test_random_traffic();
    idle_on = 1'b1;
    for (int p = 0; p < 8; p++) begin
      random_config();
      run_items(90);
    end
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    random_config();
    hold_request = 1'b1;
    run_items(40);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    random_config();
    run_items(60);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= cce_pkg::CfgGenPoly;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= cce_pkg::OpEncode;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_special_cases();
    test_random_traffic();
    test_backpressure();
    test_steady_stream();
    wait_drained();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_result.word  = m_axis_tdata[WordW-1:0];
      seen_result.syn   = m_axis_tdata[WordW +: SynW];
      seen_result.pos   = m_axis_tdata[WordW + SynW +: PosW];
      seen_result.fixed = m_axis_tdata[WordW + SynW + PosW];
      seen_result.unc   = m_axis_tdata[WordW + SynW + PosW + 1];
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MaxReported) begin
          $display("Unexpected result: word %h syndrome %h", seen_result.word, seen_result.syn);
        end
      end else begin
        due_result = pending_results.pop_front();
        if (seen_result.word !== due_result.word || seen_result.syn !== due_result.syn ||
            seen_result.pos !== due_result.pos || seen_result.fixed !== due_result.fixed ||
            seen_result.unc !== due_result.unc) begin
          error_count++;
          if (error_count <= MaxReported) begin
            $display("Mismatch: expected word %h syn %h pos %0d fixed %b unc %b",
                     due_result.word, due_result.syn, due_result.pos,
                     due_result.fixed, due_result.unc);
            $display("          actual   word %h syn %h pos %0d fixed %b unc %b",
                     seen_result.word, seen_result.syn, seen_result.pos,
                     seen_result.fixed, seen_result.unc);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
